/* hdl/mac_address_text_parser_macros.svh */
// assertion macros used by the checker file
`ifndef MAC_ADDRESS_TEXT_PARSER_MACROS_SVH
`define MAC_ADDRESS_TEXT_PARSER_MACROS_SVH

// property checked outside of reset
`define MACP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define MACP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/macp_pkg.sv */
`default_nettype none

package macp_pkg;

   localparam int unsigned AddrWidth = 48;

   // char positions that matter for the hex forms
   localparam logic [4:0] PairLen     = 5'd17;
   localparam logic [4:0] SixLen      = 5'd13;
   localparam logic [4:0] PairLastPos = 5'd16;
   localparam logic [4:0] SixLastPos  = 5'd12;
   localparam logic [4:0] SixSepPos   = 5'd6;
   localparam logic [4:0] PosMax      = 5'd31;

   // candidate bit indexes
   localparam int unsigned CandColon  = 0;
   localparam int unsigned CandHyphen = 1;
   localparam int unsigned CandSix    = 2;
   localparam int unsigned CandDec    = 3;

   localparam logic [7:0] CharColon  = 8'h3A;
   localparam logic [7:0] CharHyphen = 8'h2D;

   typedef enum logic [1:0] {
      FMT_COLON   = 2'd0,
      FMT_HYPHEN  = 2'd1,
      FMT_SIX     = 2'd2,
      FMT_DECIMAL = 2'd3
   } format_type;

   typedef struct packed {
      logic       is_hex;
      logic       is_digit;
      logic       is_colon;
      logic       is_hyphen;
      logic [3:0] nibble;
   } char_info_type;

endpackage

`default_nettype wire

/* hdl/macp_char_class.sv */
`default_nettype none

module macp_char_class
   import macp_pkg::*;
(
   input  wire logic [7:0]    char_code,
   output char_info_type      info
);

   logic is_upper;
   logic is_lower;

   always_comb begin
      is_upper = (char_code >= 8'h41) && (char_code <= 8'h46);
      is_lower = (char_code >= 8'h61) && (char_code <= 8'h66);

      info.is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
      info.is_hex    = info.is_digit || is_upper || is_lower;
      info.is_colon  = (char_code == CharColon);
      info.is_hyphen = (char_code == CharHyphen);
      // letters: low nibble 1..6 maps to 10..15
      info.nibble    = info.is_digit ? char_code[3:0] : (char_code[3:0] + 4'd9);
   end

endmodule

`default_nettype wire

/* hdl/mac_address_text_parser.sv */
// mac_address_text_parser
// Parses the text of a MAC address, one ASCII character per request.
// Request channel: req_valid / req_stall carry req_char_code and
// req_last_char; req_last_char marks the final character of one text.
// Result channel: rsp_valid / rsp_stall carry one result per text:
// rsp_valid_res, rsp_format_kind (0 colon pairs, 1 hyphen pairs,
// 2 six-hyphen-six, 3 decimal) and the 48-bit rsp_address_value.
// Non-final characters give no result. Decimal is tried first, then the
// three hex forms; an invalid text gives kind 0 and value 0.
// Throughput: one character per cycle while req_stall is low, including
// back-to-back texts. Each character updates the parse state in the
// cycle it is taken. The result is in the output register in the cycle
// after the final character is accepted.
// When the receiver stalls, the result holds in the output register and
// characters keep flowing; only a final character waits (req_stall high)
// while a result is still held and stalled.
// Reset (synchronous, active high) clears the parse state and drops any
// pending result.

`default_nettype none

module mac_address_text_parser
   import macp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_char_code,
   input  wire logic                 req_last_char,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid_res,
   output logic [1:0]                rsp_format_kind,
   output logic [AddrWidth-1:0]      rsp_address_value
);

   // parse state
   logic [4:0]           pos_ff, pos_in;
   logic [3:0]           cand_ff, cand_in;
   logic [AddrWidth-1:0] hex_ff, hex_in;
   logic [AddrWidth-1:0] dec_ff, dec_in;
   logic                 ovf_ff, ovf_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic                 res_valid_ff, res_valid_in;
   format_type           fmt_ff, fmt_in;
   logic [AddrWidth-1:0] value_ff, value_in;

   char_info_type        info;
   logic                 accept;
   logic                 pair_sep;
   logic [3:0]           kill;
   logic [3:0]           cand_next;
   logic [AddrWidth+3:0] dec_sum;
   logic                 dec_over;
   logic                 ovf_next;
   logic [AddrWidth-1:0] dec_next;
   logic [AddrWidth-1:0] hex_next;

   macp_char_class u_class (
      .char_code (req_char_code),
      .info      (info)
   );

   // a final char waits only while a stalled result is still held
   assign req_stall = out_valid_ff && rsp_stall && req_last_char;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      // separator slot of the pair forms: position mod 3 == 2, below 17
      pair_sep = (pos_ff == 5'd2) || (pos_ff == 5'd5) || (pos_ff == 5'd8) ||
                 (pos_ff == 5'd11) || (pos_ff == 5'd14);

      kill[CandColon]  = (pos_ff >= PairLen) ||
                         (pair_sep ? !info.is_colon : !info.is_hex);
      kill[CandHyphen] = (pos_ff >= PairLen) ||
                         (pair_sep ? !info.is_hyphen : !info.is_hex);
      kill[CandSix]    = (pos_ff >= SixLen) ||
                         ((pos_ff == SixSepPos) ? !info.is_hyphen : !info.is_hex);
      kill[CandDec]    = !info.is_digit;
      cand_next        = cand_ff & ~kill;

      hex_next = info.is_hex ? {hex_ff[AddrWidth-5:0], info.nibble} : hex_ff;

      // acc*10 + d as shift-add; anything above 48 bits means overflow
      dec_sum  = {1'b0, dec_ff, 3'b000} + {3'b000, dec_ff, 1'b0} +
                 {{AddrWidth{1'b0}}, info.nibble};
      dec_over = |dec_sum[AddrWidth+3:AddrWidth];

      ovf_next = ovf_ff;
      dec_next = dec_ff;
      if (info.is_digit && !ovf_ff) begin
         if (dec_over) begin
            ovf_next = 1'b1;
         end else begin
            dec_next = dec_sum[AddrWidth-1:0];
         end
      end
   end

   // next parse state: restart after the final char
   always_comb begin
      pos_in  = pos_ff;
      cand_in = cand_ff;
      hex_in  = hex_ff;
      dec_in  = dec_ff;
      ovf_in  = ovf_ff;
      if (accept) begin
         if (req_last_char) begin
            pos_in  = '0;
            cand_in = '1;
            hex_in  = '0;
            dec_in  = '0;
            ovf_in  = 1'b0;
         end else begin
            pos_in  = (pos_ff == PosMax) ? pos_ff : (pos_ff + 5'd1);
            cand_in = cand_next;
            hex_in  = hex_next;
            dec_in  = dec_next;
            ovf_in  = ovf_next;
         end
      end
   end

   // result selection, in priority order
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      res_valid_in = res_valid_ff;
      fmt_in       = fmt_ff;
      value_in     = value_ff;
      if (accept && req_last_char) begin
         out_valid_in = 1'b1;
         res_valid_in = 1'b1;
         if (cand_next[CandDec] && !ovf_next) begin
            fmt_in   = FMT_DECIMAL;
            value_in = dec_next;
         end else if (cand_next[CandColon] && (pos_ff == PairLastPos)) begin
            fmt_in   = FMT_COLON;
            value_in = hex_next;
         end else if (cand_next[CandHyphen] && (pos_ff == PairLastPos)) begin
            fmt_in   = FMT_HYPHEN;
            value_in = hex_next;
         end else if (cand_next[CandSix] && (pos_ff == SixLastPos)) begin
            fmt_in   = FMT_SIX;
            value_in = hex_next;
         end else begin
            res_valid_in = 1'b0;
            fmt_in       = FMT_COLON;
            value_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         cand_ff      <= '1;
         hex_ff       <= '0;
         dec_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         cand_ff      <= cand_in;
         hex_ff       <= hex_in;
         dec_ff       <= dec_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      res_valid_ff <= res_valid_in;
      fmt_ff       <= fmt_in;
      value_ff     <= value_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_valid_res     = res_valid_ff;
   assign rsp_format_kind   = fmt_ff;
   assign rsp_address_value = value_ff;

endmodule

`default_nettype wire

/* hdl/macp_checker.sv */
`default_nettype none

`include "mac_address_text_parser_macros.svh"

module macp_checker
   import macp_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 req_last_char,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic                 rsp_valid_res,
   input wire logic [1:0]           rsp_format_kind,
   input wire logic [AddrWidth-1:0] rsp_address_value
);

   // held result keeps its payload
   `MACP_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_valid_res, rsp_format_kind, rsp_address_value}),
      "result changed while stalled")

   // invalid result reports kind zero and value zero
   `MACP_ASSERT(a_invalid_zero, clock, reset,
      rsp_valid && !rsp_valid_res |-> rsp_format_kind == FMT_COLON &&
         rsp_address_value == '0,
      "invalid result not zeroed")

   // a fresh result follows an accepted final char
   `MACP_ASSERT(a_rsp_cause, clock, reset,
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_char),
      "result without final char")

   // no result right after reset
   `MACP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid,
      "result present after reset")

   // only final chars may be stalled
   `MACP_ASSERT(a_stall_final, clock, reset,
      req_stall |-> req_last_char && rsp_valid && rsp_stall,
      "non-final char stalled")

endmodule

bind mac_address_text_parser macp_checker u_macp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_last_char     (req_last_char),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_valid_res     (rsp_valid_res),
   .rsp_format_kind   (rsp_format_kind),
   .rsp_address_value (rsp_address_value)
);

`default_nettype wire
